// ===== rtl/core/pfma_pkg.sv =====
// Shared types, constants and arithmetic helpers for the polynomial fit moment accumulator.
package pfma_pkg;

  localparam int FRAC_BITS = 15;
  localparam int SUM_WIDTH = 64;

  localparam int SAMPLE_W  = 16;
  localparam int MOMENT_W  = 64;
  localparam int TERM_W    = 46;
  localparam int PROD_W    = TERM_W + SAMPLE_W;
  localparam int ADD_W     = ((SUM_WIDTH > TERM_W) ? SUM_WIDTH : TERM_W) + 1;

  localparam int NUM_POW   = 9;
  localparam int NUM_CROSS = 5;
  localparam int NUM_MOM   = NUM_POW + NUM_CROSS;
  localparam int CNT_W     = $clog2(NUM_MOM);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic signed [SUM_WIDTH-1:0] sum_t;
  typedef logic signed [TERM_W-1:0]    term_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ADD_W-1:0]     wide_t;

  // 1.0 in the fixed-point format of the powers.
  localparam term_t TERM_ONE =
    {{(TERM_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam prod_t TERM_HI = {{(PROD_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}};
  localparam prod_t TERM_LO = ~TERM_HI;
  localparam wide_t SUM_HI  = {{(ADD_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam wide_t SUM_LO  = ~SUM_HI;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       final_sample;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]           moment_index;
    logic signed [MOMENT_W-1:0] moment_value;
    logic                       saturated;
    logic                       last_moment;
  } out_word_t;

  typedef struct packed {
    term_t term;
    logic  ovf;
  } clamp_res_t;

  typedef struct packed {
    sum_t sum;
    logic ovf;
  } sat_res_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_ACC,
    ENG_EMIT
  } eng_state_t;

  // Floor-divide a product by 2^FRAC_BITS and clamp it to the term range.
  function automatic clamp_res_t clamp_term(prod_t p);
    prod_t      sh;
    clamp_res_t r;
    sh = p >>> FRAC_BITS;
    if (sh > TERM_HI) begin
      r.term = TERM_HI[TERM_W-1:0];
      r.ovf  = 1'b1;
    end else if (sh < TERM_LO) begin
      r.term = TERM_LO[TERM_W-1:0];
      r.ovf  = 1'b1;
    end else begin
      r.term = sh[TERM_W-1:0];
      r.ovf  = 1'b0;
    end
    return r;
  endfunction

  // Saturating add of a term into a running sum.
  function automatic sat_res_t sat_add(sum_t a, term_t b);
    wide_t    s;
    sat_res_t r;
    s = ADD_W'(a) + ADD_W'(b);
    if (s > SUM_HI) begin
      r.sum = SUM_HI[SUM_WIDTH-1:0];
      r.ovf = 1'b1;
    end else if (s < SUM_LO) begin
      r.sum = SUM_LO[SUM_WIDTH-1:0];
      r.ovf = 1'b1;
    end else begin
      r.sum = s[SUM_WIDTH-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pfma_front.sv =====
// Input side: accepts sample words into a short queue that feeds the engine.
module pfma_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfma_pkg::in_word_t  in_word,
  output logic                q_valid,
  output pfma_pkg::in_word_t  q_word,
  input  logic                q_pop
);

  pfma_pkg::in_word_t             slots [pfma_pkg::QUEUE_DEPTH];
  logic [pfma_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [pfma_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [pfma_pkg::QUEUE_AW:0]    count;
  logic                           push;
  logic                           pop;

  assign in_ready = (count != (pfma_pkg::QUEUE_AW+1)'(pfma_pkg::QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_word   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_word;
    end
  end

endmodule

// ===== rtl/core/pfma_engine.sv =====
// Back end: power chain, saturating moment sums and emission of the result words.
module pfma_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pfma_pkg::in_word_t  q_word,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output pfma_pkg::out_word_t out_word
);

  pfma_pkg::eng_state_t          state;
  pfma_pkg::eng_state_t          state_next;
  logic [pfma_pkg::CNT_W-1:0]    cnt;
  logic signed [pfma_pkg::SAMPLE_W-1:0] xs;
  logic signed [pfma_pkg::SAMPLE_W-1:0] ys;
  logic                          fin;
  pfma_pkg::term_t               pw;
  pfma_pkg::term_t               cterm;
  pfma_pkg::prod_t               prod_x;
  pfma_pkg::prod_t               prod_y;
  pfma_pkg::sum_t                pring [pfma_pkg::NUM_POW];
  pfma_pkg::sum_t                cring [pfma_pkg::NUM_CROSS];
  logic                          ovf;
  pfma_pkg::out_word_t           out_reg;
  logic                          out_vld;

  logic                          do_load;
  logic                          do_mul;
  logic                          do_acc;
  logic                          do_emit;
  logic                          cross_en;
  logic                          cross_live;
  logic                          last_step;
  logic                          last_emit;
  pfma_pkg::sat_res_t            pa;
  pfma_pkg::sat_res_t            ca;
  pfma_pkg::clamp_res_t          clx;
  pfma_pkg::clamp_res_t          cly;

  assign pa  = pfma_pkg::sat_add(pring[0], pw);
  assign ca  = pfma_pkg::sat_add(cring[0], cterm);
  assign clx = pfma_pkg::clamp_term(prod_x);
  assign cly = pfma_pkg::clamp_term(prod_y);

  // The cross term of step k-1 lands in its sum during step k.
  assign cross_en   = (cnt != '0) && (cnt <= pfma_pkg::CNT_W'(pfma_pkg::NUM_CROSS));
  // Only x^0*y..x^4*y are real cross terms; later products are discarded.
  assign cross_live = (cnt < pfma_pkg::CNT_W'(pfma_pkg::NUM_CROSS));
  assign last_step  = (cnt == pfma_pkg::CNT_W'(pfma_pkg::NUM_POW - 1));
  assign last_emit  = (cnt == pfma_pkg::CNT_W'(pfma_pkg::NUM_MOM - 1));

  assign out_valid = out_vld;
  assign out_word  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfma_pkg::ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    do_load    = 1'b0;
    do_mul     = 1'b0;
    do_acc     = 1'b0;
    do_emit    = 1'b0;
    case (state)
      pfma_pkg::ENG_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          do_load    = 1'b1;
          state_next = pfma_pkg::ENG_MUL;
        end
      end
      pfma_pkg::ENG_MUL: begin
        do_mul = 1'b1;
        if (last_step) begin
          state_next = fin ? pfma_pkg::ENG_EMIT : pfma_pkg::ENG_IDLE;
        end else begin
          state_next = pfma_pkg::ENG_ACC;
        end
      end
      pfma_pkg::ENG_ACC: begin
        do_acc     = 1'b1;
        state_next = pfma_pkg::ENG_MUL;
      end
      pfma_pkg::ENG_EMIT: begin
        if (!out_vld || out_ready) begin
          do_emit = 1'b1;
          if (last_emit) begin
            state_next = pfma_pkg::ENG_IDLE;
          end
        end
      end
      default: begin
        state_next = pfma_pkg::ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      ovf     <= 1'b0;
      out_vld <= 1'b0;
      for (int i = 0; i < pfma_pkg::NUM_POW; i++) begin
        pring[i] <= '0;
      end
      for (int i = 0; i < pfma_pkg::NUM_CROSS; i++) begin
        cring[i] <= '0;
      end
    end else begin
      if (do_load) begin
        cnt <= '0;
      end else if (do_acc) begin
        cnt <= cnt + 1'b1;
      end else if (do_mul && last_step) begin
        cnt <= '0;
      end else if (do_emit) begin
        cnt <= last_emit ? '0 : cnt + 1'b1;
      end

      // The sums live in rotating rings so that only the head is ever read.
      if (do_mul) begin
        for (int i = 0; i < pfma_pkg::NUM_POW - 1; i++) begin
          pring[i] <= pring[i+1];
        end
        pring[pfma_pkg::NUM_POW-1] <= pa.sum;
        if (cross_en) begin
          for (int i = 0; i < pfma_pkg::NUM_CROSS - 1; i++) begin
            cring[i] <= cring[i+1];
          end
          cring[pfma_pkg::NUM_CROSS-1] <= ca.sum;
        end
      end else if (do_emit) begin
        // Emission drains both rings in index order and leaves zeros behind.
        for (int i = 0; i < pfma_pkg::NUM_POW - 1; i++) begin
          pring[i] <= pring[i+1];
        end
        pring[pfma_pkg::NUM_POW-1] <= cring[0];
        for (int i = 0; i < pfma_pkg::NUM_CROSS - 1; i++) begin
          cring[i] <= cring[i+1];
        end
        cring[pfma_pkg::NUM_CROSS-1] <= '0;
      end

      if (do_mul) begin
        ovf <= ovf | pa.ovf | (cross_en & ca.ovf);
      end else if (do_acc) begin
        ovf <= ovf | clx.ovf | (cross_live & cly.ovf);
      end else if (do_emit && last_emit) begin
        ovf <= 1'b0;
      end

      if (do_emit) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      xs  <= q_word.x_sample;
      ys  <= q_word.y_sample;
      fin <= q_word.final_sample;
      pw  <= pfma_pkg::TERM_ONE;
    end
    if (do_mul) begin
      prod_x <= pfma_pkg::PROD_W'(pw) * pfma_pkg::PROD_W'(xs);
      prod_y <= pfma_pkg::PROD_W'(pw) * pfma_pkg::PROD_W'(ys);
    end
    if (do_acc) begin
      pw    <= clx.term;
      cterm <= cly.term;
    end
    if (do_emit) begin
      out_reg.moment_index <= cnt;
      out_reg.moment_value <= pfma_pkg::MOMENT_W'(pring[0]);
      out_reg.saturated    <= ovf;
      out_reg.last_moment  <= last_emit;
    end
  end

endmodule

// ===== rtl/core/poly_fit_moment_accumulator.sv =====
// Top level of the quartic least-squares moment accumulator.
// Each sample word (x, y in signed Q1.15) enters a four-word queue and is then
// worked by one engine that forms x^0..x^8 and x^0*y..x^4*y with a pair of
// shared multipliers and folds them into fourteen saturating 64-bit sums.
// A sample goes through a dispatch step, then multiply steps interleaved with
// the clamp steps of the power chain; the engine takes no new sample from the
// queue until it is done with the last one. A sample marked final is followed
// by fourteen result words, index 0..13, one per cycle while the output is
// taken; these carry the sticky saturation flag and mark index 13 as last,
// after which the sums and the flag start again from zero.
module poly_fit_moment_accumulator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfma_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output pfma_pkg::out_word_t out_word
);

  logic               q_valid;
  logic               q_pop;
  pfma_pkg::in_word_t q_word;

  pfma_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  pfma_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
